FILE: hw/rtl/isort_pkg.sv
// Shared types and defaults for the insertion sorter.
// Holds the channel payload structs and the cell-to-cell link types.
// No dependencies.
package isort_pkg;

  localparam int unsigned DepthDef = 32;
  localparam int unsigned ValueW   = 32;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } isort_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflow;
  } isort_out_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     valid;
    logic                     greater;
  } isort_link_t;

  // Broadcast control shared by every cell
  typedef struct packed {
    logic                     insert;
    logic                     shift_out;
    logic signed [ValueW-1:0] value;
  } isort_ctrl_t;

endpackage

FILE: hw/rtl/isort_cell.sv
// One slot of the sorted chain: holds a value and its valid bit.
// Inserts by compare-and-shift right, drains by shifting left.
// Depends on isort_pkg.
module isort_cell import isort_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  isort_ctrl_t ctrl_i,
  input  isort_link_t left_i,
  input  isort_link_t right_i,
  output isort_link_t link_o
);

  logic signed [ValueW-1:0] val_q, val_d;
  logic                     valid_q, valid_d;
  logic                     greater;

  assign greater = valid_q && (val_q > ctrl_i.value);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      // Move right if the new value sorts before us, or fill the first free slot
      if (greater || (left_i.valid && !valid_q)) begin
        val_d   = left_i.greater ? left_i.value : ctrl_i.value;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.shift_out) begin
      val_d   = right_i.value;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o = '{value: val_q, valid: valid_q, greater: greater};

endmodule

FILE: hw/rtl/insertion_sorter.sv
// Stable insertion sorter: a chain of Depth compare-and-shift cells.
// Loading: one value per cycle outside a drain, inserted in the same cycle it transfers.
// Output: the transfer marked last sets the drain flag, and each pop registers the head
// value into the output register; the n stored values stream out one per cycle from the
// head cell while the output does not stall, and the input is stalled for the whole drain.
// Reset empties the chain and clears the drain and overflow flags at once.
module insertion_sorter import isort_pkg::*; #(
  parameter int unsigned Depth = DepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  isort_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output isort_out_t out_data_o
);

  isort_link_t links [Depth];
  isort_ctrl_t ctrl;

  logic       drain_q;
  logic       ovf_q;
  logic       out_valid_q;
  isort_out_t out_q;
  logic       in_xfer, full, pop;

  assign full    = links[Depth-1].valid;
  assign in_xfer = in_valid_i && !drain_q;
  assign pop     = drain_q && (!out_valid_q || !out_stall_i);

  assign ctrl = '{insert: in_xfer && !full, shift_out: pop, value: in_data_i.value};

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    isort_link_t left, right;
    if (i == 0) begin : g_head
      assign left = '{value: '0, valid: 1'b1, greater: 1'b0};
    end else begin : g_mid
      assign left = links[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right = '{value: '0, valid: 1'b0, greater: 1'b0};
    end else begin : g_body
      assign right = links[i+1];
    end
    isort_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .link_o  (links[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (full) ovf_q <= 1'b1;
        if (in_data_i.last) drain_q <= 1'b1;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
        // Last stored value leaves: close the set
        if (!links[1].valid) begin
          drain_q <= 1'b0;
          ovf_q   <= 1'b0;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= '{sorted_value: links[0].value,
                 end_of_set:   !links[1].valid,
                 overflow:     ovf_q};
    end
  end

  assign in_stall_o  = drain_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A drain always has a head value to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> links[0].valid)
    else $error("drain with empty head cell");

  // Sending the final value ends the drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !links[1].valid) |=> !drain_q && !links[0].valid)
    else $error("drain did not end after final value");

  // An accepted insert always leaves the head occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> links[0].valid)
    else $error("insert left head cell empty");

  // Overflow is only raised when a transfer meets a full chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(in_xfer && full))
    else $error("overflow flag raised without a drop");

endmodule
